[sv/bas_pkg.sv]
// Shared types, constants and the channel blend function of the bilinear ARGB scaler.
// No dependencies; front end, back end, top level and testbench use scoped names.
`timescale 1ns / 1ps

package bas_pkg;

  localparam int unsigned FracBits = 16;
  localparam int unsigned StepW    = 25;
  localparam int unsigned SizeW    = 9;
  localparam int unsigned CoordW   = 16;
  localparam int unsigned IndexW   = 16;
  localparam int unsigned PixW     = 32;
  localparam int unsigned WgtW     = 9;
  localparam int unsigned ProdW    = CoordW + StepW;
  localparam int unsigned PosW     = ProdW + 2;
  localparam int unsigned CfgAddrW = 4;
  localparam int unsigned CfgDataW = 32;

  localparam logic [PosW-1:0] FracHalf = PosW'(1) << (FracBits - 1);

  typedef enum logic [1:0] {
    RegSrcWidth  = 2'd0,
    RegSrcHeight = 2'd1,
    RegStepX     = 2'd2,
    RegStepY     = 2'd3
  } reg_idx_e;

  typedef struct packed {
    logic            is_sample;
    logic [WgtW-1:0] wx;
    logic [WgtW-1:0] wy;
  } op_ctl_t;

  function automatic logic [PixW-1:0] blend(input logic [PixW-1:0] a,
                                            input logic [PixW-1:0] b,
                                            input logic [WgtW-1:0] w);
    logic [WgtW-1:0] keep;
    logic [16:0]     acc;
    logic [PixW-1:0] res;
    keep = 9'd256 - w;
    res  = '0;
    for (int c = 0; c < 4; c++) begin
      acc = 17'(a[8*c +: 8]) * 17'(keep) + 17'(b[8*c +: 8]) * 17'(w) + 17'd128;
      res[8*c +: 8] = acc[15:8];
    end
    return res;
  endfunction

endpackage

[sv/bas_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`timescale 1ns / 1ps

module bas_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 65536
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

[sv/bas_front.sv]
// Front end: maps a sample request to its four neighbor addresses and weights,
// or checks a write request, over three stages. Depends on bas_pkg.
`timescale 1ns / 1ps

module bas_front #(
  parameter int unsigned MAX_DIM = 256
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         accept_i,
  input  logic                         action_i,
  input  logic [bas_pkg::IndexW-1:0]   pixel_index_i,
  input  logic [bas_pkg::PixW-1:0]     pixel_value_i,
  input  logic [bas_pkg::CoordW-1:0]   target_x_i,
  input  logic [bas_pkg::CoordW-1:0]   target_y_i,
  input  logic [bas_pkg::SizeW-1:0]    src_width_i,
  input  logic [bas_pkg::SizeW-1:0]    src_height_i,
  input  logic [bas_pkg::StepW-1:0]    step_x_i,
  input  logic [bas_pkg::StepW-1:0]    step_y_i,
  output logic                         push_o,
  output bas_pkg::op_ctl_t             ctl_o,
  output logic [4*$clog2(MAX_DIM)*2-1:0] addr_o,
  output logic [bas_pkg::PixW-1:0]     data_o
);

  localparam int unsigned IW    = $clog2(MAX_DIM);
  localparam int unsigned AW    = 2 * IW;
  localparam int unsigned Depth = MAX_DIM * MAX_DIM;

  typedef struct packed {
    logic [IW-1:0]                lo;
    logic [IW-1:0]                hi;
    logic [bas_pkg::WgtW-1:0]     w;
  } axis_t;

  function automatic logic [bas_pkg::SizeW-1:0] eff_size(input logic [bas_pkg::SizeW-1:0] raw);
    logic [bas_pkg::SizeW-1:0] res;
    res = raw;
    if (raw == '0) begin
      res = bas_pkg::SizeW'(1);
    end else if (32'(raw) > MAX_DIM) begin
      res = bas_pkg::SizeW'(MAX_DIM);
    end
    return res;
  endfunction

  function automatic axis_t pick(input logic [bas_pkg::ProdW-1:0] prod,
                                 input logic [bas_pkg::StepW-1:0] step,
                                 input logic [bas_pkg::SizeW-1:0] size);
    logic signed [bas_pkg::PosW-1:0] pos;
    logic signed [bas_pkg::PosW-1:0] last;
    logic [31:0]                     szm1;
    logic [16:0]                     wsum;
    axis_t                           r;
    pos  = $signed({2'b00, prod}) + $signed(bas_pkg::PosW'(step >> 1))
           - $signed(bas_pkg::FracHalf);
    szm1 = 32'(size) - 32'd1;
    last = $signed(bas_pkg::PosW'(szm1) << bas_pkg::FracBits);
    r    = '0;
    if (pos <= 0 || size == bas_pkg::SizeW'(1)) begin
      r = '0;
    end else if (pos >= last) begin
      r.lo = szm1[IW-1:0];
      r.hi = szm1[IW-1:0];
    end else begin
      wsum = 17'(pos[bas_pkg::FracBits-1:0]) + 17'd128;
      r.lo = pos[bas_pkg::FracBits +: IW];
      r.hi = pos[bas_pkg::FracBits +: IW] + IW'(1);
      r.w  = wsum[16:8];
    end
    return r;
  endfunction

  logic                         f1_valid_q, f2_valid_q, f3_valid_q;
  logic                         f1_sample_q, f2_sample_q;
  logic [bas_pkg::ProdW-1:0]    prod_x_q, prod_y_q;
  logic [AW-1:0]                windex_q, windex2_q;
  logic [bas_pkg::PixW-1:0]     data1_q, data2_q, data3_q;
  axis_t                        ax_q, ay_q;
  bas_pkg::op_ctl_t             ctl_q;
  logic [4*AW-1:0]              addr_q;
  logic                         wr_ok;
  logic [bas_pkg::SizeW-1:0]    width_eff, height_eff;
  axis_t                        ax_d, ay_d;
  logic [4*AW-1:0]              addr_d;
  logic [31:0]                  a00, a01, a10, a11;

  assign wr_ok      = 32'(pixel_index_i) < Depth;
  assign width_eff  = eff_size(src_width_i);
  assign height_eff = eff_size(src_height_i);
  assign ax_d       = pick(prod_x_q, step_x_i, width_eff);
  assign ay_d       = pick(prod_y_q, step_y_i, height_eff);

  always_comb begin
    a00 = 32'(ay_q.lo) * 32'(width_eff) + 32'(ax_q.lo);
    a01 = 32'(ay_q.lo) * 32'(width_eff) + 32'(ax_q.hi);
    a10 = 32'(ay_q.hi) * 32'(width_eff) + 32'(ax_q.lo);
    a11 = 32'(ay_q.hi) * 32'(width_eff) + 32'(ax_q.hi);
    if (f2_sample_q) begin
      addr_d = {a11[AW-1:0], a10[AW-1:0], a01[AW-1:0], a00[AW-1:0]};
    end else begin
      addr_d = {{(3*AW){1'b0}}, windex2_q};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f1_valid_q <= 1'b0;
      f2_valid_q <= 1'b0;
      f3_valid_q <= 1'b0;
    end else begin
      f1_valid_q <= accept_i && (action_i || wr_ok);
      f2_valid_q <= f1_valid_q;
      f3_valid_q <= f2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    f1_sample_q     <= action_i;
    prod_x_q        <= bas_pkg::ProdW'(target_x_i) * bas_pkg::ProdW'(step_x_i);
    prod_y_q        <= bas_pkg::ProdW'(target_y_i) * bas_pkg::ProdW'(step_y_i);
    windex_q        <= AW'(pixel_index_i);
    data1_q         <= pixel_value_i;
    f2_sample_q     <= f1_sample_q;
    ax_q            <= ax_d;
    ay_q            <= ay_d;
    windex2_q       <= windex_q;
    data2_q         <= data1_q;
    ctl_q.is_sample <= f2_sample_q;
    ctl_q.wx        <= ax_q.w;
    ctl_q.wy        <= ay_q.w;
    addr_q          <= addr_d;
    data3_q         <= data2_q;
  end

  assign push_o = f3_valid_q;
  assign ctl_o  = ctl_q;
  assign addr_o = addr_q;
  assign data_o = data3_q;

endmodule

[sv/bas_queue.sv]
// Short first-in first-out queue of decoded requests between front and back end.
// No dependencies.
`timescale 1ns / 1ps

module bas_queue #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] data_i,
  input  logic             pop_i,
  output logic             not_empty_o,
  output logic             almost_full_o,
  output logic [Width-1:0] data_o
);

  localparam int unsigned PW = $clog2(Depth);
  localparam int unsigned CW = $clog2(Depth + 1);

  logic [Width-1:0] slot_q [Depth];
  logic [PW-1:0]    wr_ptr_q, rd_ptr_q;
  logic [CW-1:0]    count_q;
  logic             do_pop;

  assign not_empty_o   = count_q != '0;
  assign do_pop        = pop_i && not_empty_o;
  assign almost_full_o = 32'(count_q) + 32'd4 > Depth;
  assign data_o        = slot_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (32'(wr_ptr_q) == Depth - 1) ? '0 : wr_ptr_q + PW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (32'(rd_ptr_q) == Depth - 1) ? '0 : rd_ptr_q + PW'(1);
      end
      count_q <= count_q + CW'(push_i) - CW'(do_pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

[sv/bas_back.sv]
// Back end: four store copies serve the four neighbor reads, then horizontal
// and vertical blend stages. Depends on bas_pkg and bas_ram.
`timescale 1ns / 1ps

module bas_back #(
  parameter int unsigned MAX_DIM = 256
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           valid_i,
  input  bas_pkg::op_ctl_t               ctl_i,
  input  logic [4*$clog2(MAX_DIM)*2-1:0] addr_i,
  input  logic [bas_pkg::PixW-1:0]       data_i,
  output logic                           pop_o,
  output logic                           result_valid_o,
  output logic [bas_pkg::PixW-1:0]       sampled_pixel_o
);

  localparam int unsigned AW    = 2 * $clog2(MAX_DIM);
  localparam int unsigned Depth = MAX_DIM * MAX_DIM;

  logic [bas_pkg::PixW-1:0] rd_data [4];
  logic                     we;
  logic                     b1_valid_q, b2_valid_q, out_valid_q;
  logic [bas_pkg::WgtW-1:0] b1_wx_q, b1_wy_q, b2_wy_q;
  logic [bas_pkg::PixW-1:0] upper_q, lower_q, out_q;

  assign pop_o = valid_i;
  assign we    = valid_i && !ctl_i.is_sample;

  for (genvar g = 0; g < 4; g++) begin : g_copy
    bas_ram #(
      .Width(bas_pkg::PixW),
      .Depth(Depth)
    ) u_ram (
      .clk_i  (clk_i),
      .we_i   (we),
      .waddr_i(addr_i[AW-1:0]),
      .wdata_i(data_i),
      .raddr_i(addr_i[g*AW +: AW]),
      .rdata_o(rd_data[g])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b1_valid_q  <= 1'b0;
      b2_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      b1_valid_q  <= valid_i && ctl_i.is_sample;
      b2_valid_q  <= b1_valid_q;
      out_valid_q <= b2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    b1_wx_q <= ctl_i.wx;
    b1_wy_q <= ctl_i.wy;
    upper_q <= bas_pkg::blend(rd_data[0], rd_data[1], b1_wx_q);
    lower_q <= bas_pkg::blend(rd_data[2], rd_data[3], b1_wx_q);
    b2_wy_q <= b1_wy_q;
    out_q   <= bas_pkg::blend(upper_q, lower_q, b2_wy_q);
  end

  assign result_valid_o  = out_valid_q;
  assign sampled_pixel_o = out_q;

endmodule

[sv/bilinear_argb_scaler.sv]
// Top level of the bilinear ARGB scaler: configuration registers, front end,
// request queue and back end. Depends on bas_pkg, bas_front, bas_queue and bas_back.
`timescale 1ns / 1ps

// The block takes one request per clock, writes and samples alike, and busy
// stays low in normal use. A sample result appears on sampled_pixel_o with
// result_valid_o high for one cycle; on its way it passes three address
// stages, the queue, the registered store read and two blend stages. Writes
// give no result. The receiver cannot stall the block.
// The source store is kept in four copies so that all four neighbors of a
// sample are read in the same cycle; it holds no defined data until written.

module bilinear_argb_scaler #(
  parameter int unsigned MAX_DIM = 256
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  logic                          action_i,
  input  logic [bas_pkg::IndexW-1:0]    pixel_index_i,
  input  logic [bas_pkg::PixW-1:0]      pixel_value_i,
  input  logic [bas_pkg::CoordW-1:0]    target_x_i,
  input  logic [bas_pkg::CoordW-1:0]    target_y_i,
  output logic                          result_valid_o,
  output logic [bas_pkg::PixW-1:0]      sampled_pixel_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [bas_pkg::CfgAddrW-1:0]  paddr,
  input  logic [bas_pkg::CfgDataW-1:0]  pwdata,
  output logic [bas_pkg::CfgDataW-1:0]  prdata,
  output logic                          pready
);

  localparam int unsigned AW     = 2 * $clog2(MAX_DIM);
  localparam int unsigned EntryW = $bits(bas_pkg::op_ctl_t) + 4 * AW + bas_pkg::PixW;

  logic [bas_pkg::SizeW-1:0] src_width_q, src_height_q;
  logic [bas_pkg::StepW-1:0] step_x_q, step_y_q;
  bas_pkg::reg_idx_e         reg_sel;
  logic                      cfg_wr, accept;
  logic                      push, pop, q_valid, q_almost_full;
  bas_pkg::op_ctl_t          f_ctl, b_ctl;
  logic [4*AW-1:0]           f_addr, b_addr;
  logic [bas_pkg::PixW-1:0]  f_data, b_data;
  logic [EntryW-1:0]         q_in, q_out;

  assign pready  = 1'b1;
  assign reg_sel = bas_pkg::reg_idx_e'(paddr[3:2]);
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign busy    = q_almost_full;
  assign accept  = start && !busy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_width_q  <= bas_pkg::SizeW'(1);
      src_height_q <= bas_pkg::SizeW'(1);
      step_x_q     <= bas_pkg::StepW'(65536);
      step_y_q     <= bas_pkg::StepW'(65536);
    end else if (cfg_wr) begin
      unique case (reg_sel)
        bas_pkg::RegSrcWidth:  src_width_q  <= pwdata[bas_pkg::SizeW-1:0];
        bas_pkg::RegSrcHeight: src_height_q <= pwdata[bas_pkg::SizeW-1:0];
        bas_pkg::RegStepX:     step_x_q     <= pwdata[bas_pkg::StepW-1:0];
        bas_pkg::RegStepY:     step_y_q     <= pwdata[bas_pkg::StepW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      bas_pkg::RegSrcWidth:  prdata = bas_pkg::CfgDataW'(src_width_q);
      bas_pkg::RegSrcHeight: prdata = bas_pkg::CfgDataW'(src_height_q);
      bas_pkg::RegStepX:     prdata = bas_pkg::CfgDataW'(step_x_q);
      bas_pkg::RegStepY:     prdata = bas_pkg::CfgDataW'(step_y_q);
      default:               prdata = '0;
    endcase
  end

  bas_front #(
    .MAX_DIM(MAX_DIM)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accept_i     (accept),
    .action_i     (action_i),
    .pixel_index_i(pixel_index_i),
    .pixel_value_i(pixel_value_i),
    .target_x_i   (target_x_i),
    .target_y_i   (target_y_i),
    .src_width_i  (src_width_q),
    .src_height_i (src_height_q),
    .step_x_i     (step_x_q),
    .step_y_i     (step_y_q),
    .push_o       (push),
    .ctl_o        (f_ctl),
    .addr_o       (f_addr),
    .data_o       (f_data)
  );

  assign q_in = {f_ctl, f_addr, f_data};

  bas_queue #(
    .Width(EntryW),
    .Depth(8)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .data_i       (q_in),
    .pop_i        (pop),
    .not_empty_o  (q_valid),
    .almost_full_o(q_almost_full),
    .data_o       (q_out)
  );

  assign {b_ctl, b_addr, b_data} = q_out;

  bas_back #(
    .MAX_DIM(MAX_DIM)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .valid_i        (q_valid),
    .ctl_i          (b_ctl),
    .addr_i         (b_addr),
    .data_i         (b_data),
    .pop_o          (pop),
    .result_valid_o (result_valid_o),
    .sampled_pixel_o(sampled_pixel_o)
  );

endmodule

[sv/bas_checker.sv]
// Port-level checker for the bilinear ARGB scaler and its bind to the top level.
// Depends on the ports of bilinear_argb_scaler only.
`timescale 1ns / 1ps

module bas_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic start,
  input logic busy,
  input logic action_i,
  input logic result_valid_o,
  input logic pready
);

  logic sample_req;
  assign sample_req = start && !busy && action_i;

  // The back end drains the queue every cycle, so it never backs up.
  a_never_busy: assert property (@(posedge clk_i) disable iff (!rst_ni) !busy)
    else $error("busy raised although the queue drains every cycle");

  a_sample_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sample_req |-> ##7 result_valid_o)
    else $error("sample request gave no result after seven cycles");

  a_result_has_request: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> $past(sample_req, 7))
    else $error("result without a matching sample request");

  a_pready_high: assert property (@(posedge clk_i) disable iff (!rst_ni) pready)
    else $error("pready dropped");

endmodule

bind bilinear_argb_scaler bas_checker u_bas_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .start         (start),
  .busy          (busy),
  .action_i      (action_i),
  .result_valid_o(result_valid_o),
  .pready        (pready)
);

[dv/tb_top.sv]
// Self-checking testbench for the bilinear ARGB scaler: directed rows, then random phases.
// Depends on bas_pkg and bilinear_argb_scaler; results are compared against a local predictor.
`timescale 1ns / 1ps

module tb_top;

  localparam logic ActWrite  = 1'b0;
  localparam logic ActSample = 1'b1;
  localparam int   StallLimit = 4000;
  localparam int   DrainCycles = 12;

  typedef struct {
    logic        act;
    logic [15:0] idx;
    logic [31:0] val;
    logic [15:0] x;
    logic [15:0] y;
    bit          has_exp;
    logic [31:0] exp_pix;
  } dir_row_t;

  logic        clk_i, rst_ni;
  logic        start, busy;
  logic        action_i;
  logic [15:0] pixel_index_i, target_x_i, target_y_i;
  logic [31:0] pixel_value_i;
  logic        result_valid_o;
  logic [31:0] sampled_pixel_o;
  logic        psel, penable, pwrite, pready;
  logic [bas_pkg::CfgAddrW-1:0] paddr;
  logic [31:0] pwdata, prdata;

  logic [31:0] src_img [65536];
  bit          written [65536];
  int unsigned cur_w, cur_h, cur_sx, cur_sy;
  logic [31:0] pixel_q [$];
  int          errors;
  int          stall_cnt;
  bit          quiet;
  dir_row_t    dir_rows [8];

  bilinear_argb_scaler dut (
    .clk_i, .rst_ni, .start, .busy, .action_i, .pixel_index_i, .pixel_value_i,
    .target_x_i, .target_y_i, .result_valid_o, .sampled_pixel_o,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic int unsigned eff_dim(int unsigned raw);
    if (raw == 0) return 1;
    if (raw > 256) return 256;
    return raw;
  endfunction

  function automatic void axis_pos(input int unsigned step, input int unsigned coord,
                                   input int unsigned size, output int unsigned lo,
                                   output int unsigned hi, output int unsigned frac);
    longint pos;
    longint last;
    pos  = longint'(step >> 1) - 32768 + longint'(coord) * longint'(step);
    last = longint'(size - 1) << 16;
    lo = 0; hi = 0; frac = 0;
    if (pos <= 0 || size == 1) return;
    if (pos >= last) begin
      lo = size - 1; hi = size - 1;
      return;
    end
    lo   = int'(pos >> 16);
    hi   = lo + 1;
    frac = int'(pos & 64'hffff);
  endfunction

  function automatic logic [31:0] mix_channels(logic [31:0] a, logic [31:0] b,
                                               int unsigned frac);
    int unsigned wt, c;
    logic [31:0] r;
    wt = ((frac << 8) + 32768) >> 16;
    r = '0;
    for (int s = 0; s < 4; s++) begin
      c = (a[8*s +: 8] * (256 - wt) + b[8*s +: 8] * wt + 128) >> 8;
      r[8*s +: 8] = c[7:0];
    end
    return r;
  endfunction

  function automatic logic [31:0] interp_pixel(int unsigned x, int unsigned y);
    int unsigned w, h, x0, x1, fx, y0, y1, fy;
    logic [31:0] up, dn;
    w = eff_dim(cur_w);
    h = eff_dim(cur_h);
    axis_pos(cur_sx, x, w, x0, x1, fx);
    axis_pos(cur_sy, y, h, y0, y1, fy);
    up = mix_channels(src_img[y0*w + x0], src_img[y0*w + x1], fx);
    dn = mix_channels(src_img[y1*w + x0], src_img[y1*w + x1], fx);
    return mix_channels(up, dn, fy);
  endfunction

  task automatic send_request(logic act, logic [15:0] idx, logic [31:0] val,
                              logic [15:0] x, logic [15:0] y, bit has_exp = 0,
                              logic [31:0] exp_pix = '0);
    if (!quiet && $urandom_range(1, 100) <= 30) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk_i);
    end
    start         <= 1'b1;
    action_i      <= act;
    pixel_index_i <= idx;
    pixel_value_i <= val;
    target_x_i    <= x;
    target_y_i    <= y;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    if (act == ActWrite) begin
      src_img[idx] = val;
      written[idx] = 1'b1;
    end else begin
      pixel_q.push_back(has_exp ? exp_pix : interp_pixel(x, y));
    end
  endtask

  task automatic reg_write(bas_pkg::reg_idx_e r, logic [31:0] data);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= bas_pkg::CfgAddrW'(4 * int'(r));
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    case (r)
      bas_pkg::RegSrcWidth:  cur_w  = data & 32'h1ff;
      bas_pkg::RegSrcHeight: cur_h  = data & 32'h1ff;
      bas_pkg::RegStepX:     cur_sx = data & 32'h1ffffff;
      default:               cur_sy = data & 32'h1ffffff;
    endcase
  endtask

  task automatic wait_idle();
    start <= 1'b0;
    while (pixel_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  function automatic int unsigned pick_step(int unsigned size);
    if ($urandom_range(1, 8) == 1) return $urandom & 32'h1ffffff;
    return (size << 16) / $urandom_range(1, 3 * size);
  endfunction

  task automatic run_phase(int unsigned w_raw, int unsigned h_raw, int unsigned sx,
                           int unsigned sy, int n);
    int unsigned w, h, span_x, span_y;
    logic [15:0] x, y, idx;
    wait_idle();
    reg_write(bas_pkg::RegSrcWidth, w_raw | ($urandom << 9));
    reg_write(bas_pkg::RegSrcHeight, h_raw | ($urandom << 9));
    reg_write(bas_pkg::RegStepX, sx | (($urandom & 32'h7f) << 25));
    reg_write(bas_pkg::RegStepY, sy | (($urandom & 32'h7f) << 25));
    w = eff_dim(cur_w);
    h = eff_dim(cur_h);
    for (int i = 0; i < w * h; i++)
      if (!written[i]) send_request(ActWrite, 16'(i), $urandom, 16'($urandom), 16'($urandom));
    span_x = (cur_sx == 0) ? 64 : ((w << 16) / cur_sx) + 2;
    span_y = (cur_sy == 0) ? 64 : ((h << 16) / cur_sy) + 2;
    if (span_x > 65535) span_x = 65535;
    if (span_y > 65535) span_y = 65535;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(1, 4) == 1) begin
        idx = ($urandom_range(1, 5) == 1) ? 16'($urandom) : 16'($urandom_range(0, w*h - 1));
        send_request(ActWrite, idx, $urandom, 16'($urandom), 16'($urandom));
      end else begin
        x = ($urandom_range(1, 5) == 1) ? 16'($urandom) : 16'($urandom_range(0, span_x));
        y = ($urandom_range(1, 5) == 1) ? 16'($urandom) : 16'($urandom_range(0, span_y));
        send_request(ActSample, 16'($urandom), $urandom, x, y);
      end
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && result_valid_o) begin
      if (pixel_q.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %h", $realtime,
                 sampled_pixel_o);
        errors++;
      end else if (pixel_q[0] !== sampled_pixel_o) begin
        $display("%0t: sampled_pixel mismatch, expected %h, actual %h", $realtime,
                 pixel_q[0], sampled_pixel_o);
        errors++;
        void'(pixel_q.pop_front());
      end else begin
        void'(pixel_q.pop_front());
      end
    end
  end

  always @(posedge clk_i) begin
    if ((start && !busy) || result_valid_o || psel) stall_cnt <= 0;
    else stall_cnt <= stall_cnt + 1;
    if (stall_cnt >= StallLimit) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    int unsigned w, h;
    errors = 0; stall_cnt = 0; quiet = 0;
    cur_w = 1; cur_h = 1; cur_sx = 65536; cur_sy = 65536;
    start = 0; action_i = 0; pixel_index_i = 0; pixel_value_i = 0;
    target_x_i = 0; target_y_i = 0;
    psel = 0; penable = 0; pwrite = 0; paddr = '0; pwdata = '0;
    foreach (written[i]) written[i] = 0;
    dir_rows[0] = '{ActWrite,  16'h0000, 32'ha5c3_0ff0, 16'h0,    16'h0,    0, 32'h0};
    dir_rows[1] = '{ActSample, 16'h0000, 32'h0,         16'h0,    16'h0,    1, 32'ha5c3_0ff0};
    dir_rows[2] = '{ActSample, 16'hffff, 32'hffff_ffff, 16'hffff, 16'hffff, 1, 32'ha5c3_0ff0};
    dir_rows[3] = '{ActWrite,  16'hffff, 32'hffff_ffff, 16'h0,    16'h0,    0, 32'h0};
    dir_rows[4] = '{ActWrite,  16'h0000, 32'h0000_0000, 16'h0,    16'h0,    0, 32'h0};
    dir_rows[5] = '{ActSample, 16'h0,    32'h0,         16'h1234, 16'h8000, 1, 32'h0};
    dir_rows[6] = '{ActWrite,  16'h0000, 32'hffff_ffff, 16'hffff, 16'hffff, 0, 32'h0};
    dir_rows[7] = '{ActSample, 16'h0,    32'h0,         16'h0001, 16'hffff, 1, 32'hffff_ffff};
    rst_ni = 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (dir_rows[i])
      send_request(dir_rows[i].act, dir_rows[i].idx, dir_rows[i].val, dir_rows[i].x,
                   dir_rows[i].y, dir_rows[i].has_exp, dir_rows[i].exp_pix);
    run_phase(0, 0, 0, 0, 10);
    run_phase(2, 2, 32768, 21845, 20);
    run_phase(511, 1, 16777216, 0, 30);
    run_phase(2, 128, 0, 16777216, 30);
    run_phase(256, 1, 65536 * 256 / 300, 65536, 30);
    run_phase(1, 256, 65536, 65536 * 256 / 100, 30);
    for (int p = 0; p < 7; p++) begin
      w = $urandom_range(1, 12);
      h = $urandom_range(1, 12);
      if (p == 6) quiet = 1;
      run_phase(w, h, pick_step(w), pick_step(h), 30);
    end
    wait_idle();
    if (errors == 0 && pixel_q.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
